/* src/hbp_pkg.sv */
// ----------------------------------------------------------------------------
// Huffman bit packer package
// Shared widths, table geometry and request operation codes.
// ----------------------------------------------------------------------------
package hbp_pkg;

   localparam int MAX_CODE_LEN = 32;
   localparam int SYMBOL_COUNT = 256;

   localparam int OP_W     = 2;
   localparam int SYM_W    = 8;
   localparam int CODE_W   = 32;
   localparam int LEN_W    = 6;
   localparam int BYTE_W   = 8;
   localparam int CNT_W    = 3;
   localparam int ADDR_W   = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
   localparam int ENTRY_W  = CODE_W + LEN_W;
   localparam int CAP_LEN  = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
   localparam int REQ_W    = 48;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD   = 2'd0,
      OP_ENCODE = 2'd1,
      OP_FLUSH  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

endpackage

/* src/hbp_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/huffman_bit_packer_unit.sv */
// ----------------------------------------------------------------------------
// Huffman bit packer
// Loads a symbol code table and packs looked-up codes MSB first into bytes.
// ----------------------------------------------------------------------------
// Load: the table entry is written and ready stays high. Flush: emits pending
// bits zero-padded as a last byte, waiting while the output is stalled. Encode:
// the table read is registered and ALIGN left-aligns the code; then one shared
// shift step per cycle, unless a full byte waits on a stalled output, moves up to
// 8 - pending bits; a 32-bit code takes at most 5 steps. Reset clears the
// sequencer, accumulator and output valid; table entries stay undefined until loaded.
module huffman_bit_packer_unit
   import hbp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [REQ_W-1:0]  req_tdata,   // symbol, code_value, code_length, zero pad
   input  logic [OP_W-1:0]   req_tuser,   // operation
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [BYTE_W-1:0] rsp_tdata,   // packed_byte
   output logic              rsp_tlast    // last_of_run
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ALIGN,
      ST_PACK,
      ST_FLUSH
   } state_type;

   state_type             state_ff, state_in;
   logic [CODE_W-1:0]     code_ff, code_in;
   logic [LEN_W-1:0]      rem_ff, rem_in;
   logic [BYTE_W-1:0]     acc_ff, acc_in;
   logic [CNT_W-1:0]      pend_ff, pend_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]     rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic [SYM_W-1:0]      req_symbol;
   logic [CODE_W-1:0]     req_code;
   logic [LEN_W-1:0]      req_len;
   logic [LEN_W-1:0]      sat_len;
   logic                  sym_ok;
   logic                  req_fire;
   logic                  wr_en;
   logic                  rd_en;
   logic [ENTRY_W-1:0]    rd_entry;
   logic [CODE_W-1:0]     rd_code;
   logic [LEN_W-1:0]      rd_len;

   logic [CNT_W:0]        free_bits;
   logic [CNT_W:0]        take;
   logic [BYTE_W-1:0]     chunk;
   logic [BYTE_W-1:0]     acc_shift;
   logic [BYTE_W-1:0]     acc_next;
   logic [CNT_W:0]        pend_sum;
   logic [LEN_W-1:0]      rem_next;
   logic                  out_free;
   logic [CNT_W:0]        pad_bits;

   assign req_symbol = req_tdata[SYM_W-1:0];
   assign req_code   = req_tdata[SYM_W +: CODE_W];
   assign req_len    = req_tdata[SYM_W+CODE_W +: LEN_W];
   assign sat_len    = (req_len > LEN_W'(CAP_LEN)) ? LEN_W'(CAP_LEN) : req_len;
   assign sym_ok     = ({1'b0, req_symbol} < (SYM_W+1)'(SYMBOL_COUNT));

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign wr_en      = req_fire && (req_tuser == OP_LOAD) && sym_ok;
   assign rd_en      = req_fire && (req_tuser == OP_ENCODE) && sym_ok;

   hbp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SYMBOL_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (req_symbol[ADDR_W-1:0]),
      .wr_data ({sat_len, req_code}),
      .rd_en   (rd_en),
      .rd_addr (req_symbol[ADDR_W-1:0]),
      .rd_data (rd_entry)
   );

   assign rd_code = rd_entry[CODE_W-1:0];
   assign rd_len  = rd_entry[CODE_W +: LEN_W];

   // shared shift step
   assign free_bits = (CNT_W+1)'(BYTE_W) - {1'b0, pend_ff};
   assign take      = (rem_ff < LEN_W'(free_bits)) ? (CNT_W+1)'(rem_ff) : free_bits;
   assign chunk     = code_ff[CODE_W-1 -: BYTE_W] >> ((CNT_W+1)'(BYTE_W) - take);
   assign acc_shift = acc_ff << take;
   assign acc_next  = acc_shift | chunk;
   assign pend_sum  = {1'b0, pend_ff} + take;
   assign rem_next  = rem_ff - LEN_W'(take);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign pad_bits  = (CNT_W+1)'(BYTE_W) - {1'b0, pend_ff};

   always_comb begin
      state_in     = state_ff;
      code_in      = code_ff;
      rem_in       = rem_ff;
      acc_in       = acc_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (rd_en) begin
               state_in = ST_ALIGN;
            end else if (req_fire && (req_tuser == OP_FLUSH)) begin
               state_in = ST_FLUSH;
            end
         end
         ST_ALIGN: begin
            code_in  = rd_code << (LEN_W'(CODE_W) - rd_len);
            rem_in   = rd_len;
            state_in = ST_PACK;
         end
         ST_PACK: begin
            if (rem_ff == '0) begin
               state_in = ST_IDLE;
            end else if (!pend_sum[CNT_W] || out_free) begin
               code_in = code_ff << take;
               rem_in  = rem_next;
               if (pend_sum[CNT_W]) begin
                  acc_in       = '0;
                  pend_in      = '0;
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = acc_next;
                  rsp_last_in  = (rem_next < LEN_W'(BYTE_W));
               end else begin
                  acc_in  = acc_next;
                  pend_in = pend_sum[CNT_W-1:0];
               end
            end
         end
         ST_FLUSH: begin
            if (pend_ff == '0) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = acc_ff << pad_bits;
               rsp_last_in  = 1'b1;
               acc_in       = '0;
               pend_in      = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         pend_ff      <= '0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         pend_ff      <= pend_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      code_ff     <= code_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* src/hbp_checker.sv */
// ----------------------------------------------------------------------------
// Huffman bit packer port checker
// Port-level properties of the packer, bound to the top level.
// ----------------------------------------------------------------------------
module hbp_checker
   import hbp_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic [OP_W-1:0]   req_tuser,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [BYTE_W-1:0] rsp_tdata,
   input logic              rsp_tlast
);

   logic req_fire;

   assign req_fire = req_tvalid && req_tready;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled response changed");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_tuser == OP_LOAD) |=> !$rose(rsp_tvalid) && req_tready)
      else $error("load request produced a response or stalled");

   a_encode_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_tuser == OP_ENCODE) |=> !req_tready)
      else $error("ready while encode in progress");

endmodule

bind huffman_bit_packer_unit hbp_checker u_hbp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
